@@ rtl/mgac_pkg.sv @@
package mgac_pkg;

	localparam int RegCount = 6;
	localparam int AddrWidth = 5;

	localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
	localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
	localparam logic [2:0] CMD_CLOCK    = 3'd2;
	localparam logic [2:0] CMD_START    = 3'd3;
	localparam logic [2:0] CMD_STOP     = 3'd4;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] RESTART_NONE    = 2'd0;
	localparam logic [1:0] RESTART_RELEASE = 2'd1;
	localparam logic [1:0] RESTART_START   = 2'd2;

	localparam logic [2:0] REG_ARP_ENABLE     = 3'd0;
	localparam logic [2:0] REG_RETRIG_ON_NEW  = 3'd1;
	localparam logic [2:0] REG_LFO_NOTE_SYNC  = 3'd2;
	localparam logic [2:0] REG_ARP_DIVIDER    = 3'd3;
	localparam logic [2:0] REG_LFO_DIVIDER    = 3'd4;
	localparam logic [2:0] REG_ARP_SHIFT      = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] note;
		logic [6:0] velocity;
	} mgac_event_t;

	typedef struct packed {
		logic        gate;
		logic        sync_led;
		logic        lfo_reset_pulse;
		logic        retrigger;
		logic [1:0]  note_action;
		logic [6:0]  note_number;
		logic [6:0]  note_velocity;
		logic        arp_update;
		logic        arp_step;
		logic [1:0]  arp_restart;
		logic        external_clock;
		logic [15:0] tick_position;
	} mgac_result_t;

	typedef struct packed {
		logic       arp_enable;
		logic       retrig_on_new;
		logic       lfo_note_sync;
		logic [7:0] arp_divider;
		logic [7:0] lfo_divider;
		logic [7:0] arp_shift;
	} mgac_cfg_t;

endpackage

@@ rtl/mgac_cfg_regs.sv @@
module mgac_cfg_regs import mgac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output mgac_cfg_t            cfg
);

	logic       wr_en;
	logic [2:0] reg_sel;
	mgac_cfg_t  cfg_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[AddrWidth-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arp_enable    <= 1'b0;
			cfg_q.retrig_on_new <= 1'b1;
			cfg_q.lfo_note_sync <= 1'b0;
			cfg_q.arp_divider   <= 8'd6;
			cfg_q.lfo_divider   <= 8'd24;
			cfg_q.arp_shift     <= 8'd1;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ARP_ENABLE:    cfg_q.arp_enable    <= pwdata[0];
				REG_RETRIG_ON_NEW: cfg_q.retrig_on_new <= pwdata[0];
				REG_LFO_NOTE_SYNC: cfg_q.lfo_note_sync <= pwdata[0];
				REG_ARP_DIVIDER:   cfg_q.arp_divider   <= pwdata[7:0];
				REG_LFO_DIVIDER:   cfg_q.lfo_divider   <= pwdata[7:0];
				REG_ARP_SHIFT:     cfg_q.arp_shift     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (reg_sel)
			REG_ARP_ENABLE:    prdata = {31'd0, cfg_q.arp_enable};
			REG_RETRIG_ON_NEW: prdata = {31'd0, cfg_q.retrig_on_new};
			REG_LFO_NOTE_SYNC: prdata = {31'd0, cfg_q.lfo_note_sync};
			REG_ARP_DIVIDER:   prdata = {24'd0, cfg_q.arp_divider};
			REG_LFO_DIVIDER:   prdata = {24'd0, cfg_q.lfo_divider};
			REG_ARP_SHIFT:     prdata = {24'd0, cfg_q.arp_shift};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/mgac_core.sv @@
module mgac_core import mgac_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         commit,
	input  mgac_event_t  evt,
	input  mgac_cfg_t    cfg,
	output mgac_result_t result
);

	logic [7:0]  held_q, held_d, held_dec, held_inc;
	logic        gate_q, gate_d;
	logic        led_q, led_d;
	logic [7:0]  arp_cnt_q, arp_cnt_d, arp_mid;
	logic [7:0]  lfo_cnt_q, lfo_cnt_d, lfo_next;
	logic [15:0] total_q, total_d;
	logic        ext_q, ext_d;
	logic [7:0]  half;
	logic        force_low;

	assign held_dec = (held_q == 8'd0) ? 8'd0 : held_q - 8'd1;
	assign held_inc = (held_q == 8'hFF) ? 8'hFF : held_q + 8'd1;
	assign lfo_next = lfo_cnt_q + 8'd1;
	assign half     = cfg.arp_divider - {1'b0, cfg.arp_divider[7:1]};

	always_comb begin
		held_d    = held_q;
		gate_d    = gate_q;
		led_d     = led_q;
		arp_cnt_d = arp_cnt_q;
		arp_mid   = arp_cnt_q;
		lfo_cnt_d = lfo_cnt_q;
		total_d   = total_q;
		ext_d     = ext_q;
		force_low = 1'b0;
		result    = '0;

		unique case (evt.command)
			CMD_NOTE_ON: begin
				result.lfo_reset_pulse = cfg.lfo_note_sync;
				if (evt.velocity == 7'd0) begin
					result.note_action = ACT_REMOVE;
					held_d = held_dec;
					if (held_dec == 8'd0)
						gate_d = 1'b0;
				end else begin
					result.note_action   = ACT_ADD;
					result.note_velocity = evt.velocity;
					held_d = held_inc;
					if (cfg.arp_enable) begin
						result.arp_update = 1'b1;
					end else if (cfg.retrig_on_new && held_inc > 8'd1) begin
						force_low        = 1'b1;
						result.retrigger = 1'b1;
						gate_d           = 1'b1;
					end else begin
						gate_d = 1'b1;
					end
				end
			end
			CMD_NOTE_OFF: begin
				result.note_action = ACT_REMOVE;
				held_d = held_dec;
				if (cfg.arp_enable) begin
					if (held_dec == 8'd0)
						result.arp_restart = RESTART_RELEASE;
					result.arp_update = 1'b1;
				end else if (held_dec == 8'd0) begin
					gate_d = 1'b0;
				end
			end
			CMD_CLOCK: begin
				total_d = total_q + 16'd1;
				if (lfo_next == cfg.lfo_divider) begin
					result.lfo_reset_pulse = 1'b1;
					lfo_cnt_d = 8'd0;
				end else begin
					lfo_cnt_d = lfo_next;
				end
				if (cfg.arp_enable) begin
					if (arp_cnt_q == cfg.arp_divider) begin
						arp_mid = 8'd0;
						if (held_q != 8'd0) begin
							result.arp_step = 1'b1;
							gate_d = 1'b1;
							led_d  = 1'b1;
						end
					end
					if (arp_mid == half) begin
						gate_d = 1'b0;
						led_d  = 1'b0;
					end
					arp_cnt_d = arp_mid + 8'd1;
				end
			end
			CMD_START: begin
				lfo_cnt_d = 8'd0;
				arp_cnt_d = cfg.arp_divider - cfg.arp_shift;
				ext_d     = 1'b1;
				total_d   = 16'd0;
				result.arp_restart = RESTART_START;
			end
			CMD_STOP: ext_d = 1'b0;
			default: ;
		endcase

		result.gate           = gate_d && !force_low;
		result.sync_led       = led_d;
		result.note_number    = (result.note_action != ACT_NONE) ? evt.note : 7'd0;
		result.external_clock = ext_d;
		result.tick_position  = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= 8'd0;
			gate_q    <= 1'b0;
			led_q     <= 1'b0;
			arp_cnt_q <= 8'd1;
			lfo_cnt_q <= 8'd0;
			total_q   <= 16'd0;
			ext_q     <= 1'b0;
		end else if (commit) begin
			held_q    <= held_d;
			gate_q    <= gate_d;
			led_q     <= led_d;
			arp_cnt_q <= arp_cnt_d;
			lfo_cnt_q <= lfo_cnt_d;
			total_q   <= total_d;
			ext_q     <= ext_d;
		end
	end

	// held count moves by at most one per event
	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (held_q == $past(held_q) || held_q == $past(held_q) + 8'd1 ||
			held_q == $past(held_q) - 8'd1))
		else $error("held note count jumped");

	a_start_realign: assert property (@(posedge clk) disable iff (!arst_n)
		commit && evt.command == CMD_START |=> ext_q && total_q == 16'd0 && lfo_cnt_q == 8'd0)
		else $error("start did not realign counters");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(held_q) && $stable(total_q) && $stable(arp_cnt_q))
		else $error("state changed without an event");

endmodule

@@ rtl/midi_gate_and_arp_clock.sv @@
// channel   direction  handshake                      payload
// event     in         event_valid / event_ready      event_beat  (mgac_event_t)
// result    out        result_valid / result_ready    result_beat (mgac_result_t)
// config    in         psel / penable / pready        paddr, pwdata, prdata
//
// one beat per cycle sustained while result_ready holds high; each event beat passes
// through the event register and the combinational update logic into the result register
// arst_n clears levels and counters, arp counter to 1; config registers return to defaults
// a stalled result holds the result register, the event register then fills and
// event_ready drops until the result beat is taken
module midi_gate_and_arp_clock import mgac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 event_valid,
	output logic                 event_ready,
	input  mgac_event_t          event_beat,
	output logic                 result_valid,
	input  logic                 result_ready,
	output mgac_result_t         result_beat,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	mgac_cfg_t    cfg;
	logic         evt_valid_s1;
	mgac_event_t  evt_s1;
	logic         res_valid_s2;
	mgac_result_t res_s2;
	mgac_result_t res_next;
	logic         advance;

	assign advance      = evt_valid_s1 && (!res_valid_s2 || result_ready);
	assign event_ready  = !evt_valid_s1 || advance;
	assign result_valid = res_valid_s2;
	assign result_beat  = res_s2;

	mgac_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mgac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.evt    (evt_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (event_ready)
				evt_valid_s1 <= event_valid;
			if (advance)
				res_valid_s2 <= 1'b1;
			else if (result_ready)
				res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ready && event_valid)
			evt_s1 <= event_beat;
		if (advance)
			res_s2 <= res_next;
	end

	a_retrig_drops_gate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.retrigger |-> !res_s2.gate && res_s2.note_action == ACT_ADD)
		else $error("retrigger without gate drop");

	a_step_gate_led: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.arp_step |-> res_s2.gate == res_s2.sync_led)
		else $error("arp step gate and led disagree");

	a_velocity_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.note_velocity != 7'd0 |-> res_s2.note_action == ACT_ADD)
		else $error("velocity forwarded without add");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && !result_ready |=> res_valid_s2 && $stable(res_s2))
		else $error("unaccepted result lost");

endmodule
